[hdl/receiver_watchdog_reset_escalation_defines.svh]
// ----------------------------------------------------------------------------
// Receiver watchdog assertion macros
// Shared assertion forms for the receiver watchdog RTL.
// ----------------------------------------------------------------------------
`ifndef RECEIVER_WATCHDOG_RESET_ESCALATION_DEFINES_SVH
`define RECEIVER_WATCHDOG_RESET_ESCALATION_DEFINES_SVH

// Check a condition at every clock edge outside reset
`define RWRE_ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle
`define RWRE_ASSERT_NEXT(lbl, clk, rst, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

[hdl/rwre_pkg.sv]
// ----------------------------------------------------------------------------
// Receiver watchdog package
// Item, result and configuration types, codes and the wait limit function.
// ----------------------------------------------------------------------------
package rwre_pkg;

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_FIX     = 2'd1,
    ACT_REQUEST = 2'd2,
    ACT_APPLIED = 2'd3
  } action_t;

  // Receiver modes
  localparam logic [2:0] MODE_NONE     = 3'd0;
  localparam logic [2:0] MODE_INACTIVE = 3'd1;
  localparam logic [2:0] MODE_SAVE     = 3'd2;
  localparam logic [2:0] MODE_HIGHEST  = 3'd4;

  // Reset request kinds
  localparam logic [1:0] RESET_NONE = 2'd0;
  localparam logic [1:0] RESET_WARM = 2'd2;
  localparam logic [1:0] RESET_COLD = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_TIMEOUTS = 3'd0;
  localparam logic [2:0] REG_MIN_RATE = 3'd1;
  localparam logic [2:0] REG_DEF_WAIT = 3'd2;
  localparam logic [2:0] REG_SLACK    = 3'd3;
  localparam logic [2:0] REG_AGE      = 3'd4;

  // Configuration reset values
  localparam logic [7:0]  TIMEOUTS_RST = 8'd3;
  localparam logic [15:0] MIN_RATE_RST = 16'd100;
  localparam logic [15:0] DEF_WAIT_RST = 16'd2000;
  localparam logic [15:0] SLACK_RST    = 16'd1000;
  localparam logic [31:0] AGE_RST      = 32'd4233600000;

  localparam logic [15:0] RATE_UNKNOWN = 16'hFFFF;
  localparam logic [16:0] ELAPSED_MAX  = 17'h1FFFF;
  localparam logic [7:0]  COUNT_MAX    = 8'hFF;
  localparam logic [1:0]  LEVEL_MAX    = 2'd2;

  typedef struct packed {
    logic [7:0]  timeouts_before_reset;
    logic [15:0] min_rate_ms;
    logic [15:0] default_wait_ms;
    logic [15:0] slack_ms;
    logic [31:0] age_limit_ms;
  } cfg_t;

  typedef struct packed {
    action_t     action;
    logic [31:0] uptime_ms;
    logic [2:0]  requested_mode;
    logic        apply_ok;
    logic [15:0] reported_rate_ms;
  } item_t;

  typedef struct packed {
    logic        fix_published;
    logic        timeout_event;
    logic [1:0]  reset_kind;
    logic        forward_request;
    logic        mode_report_valid;
    logic [2:0]  current_mode_out;
    logic [16:0] wait_limit_ms;
  } result_t;

  // Wait limit from the rate in force; a zero limit is raised to one
  function automatic logic [16:0] wait_limit(input logic [15:0] rate, input cfg_t cfg);
    logic [16:0] w;
    if (rate == RATE_UNKNOWN || rate < cfg.min_rate_ms) begin
      w = {1'b0, cfg.default_wait_ms};
    end else begin
      w = {1'b0, rate} + {1'b0, cfg.slack_ms};
    end
    if (w == 17'd0) begin
      w = 17'd1;
    end
    return w;
  endfunction

endpackage

[hdl/rwre_cfg.sv]
// ----------------------------------------------------------------------------
// Receiver watchdog configuration registers
// Holds the five settings, written one at a time through the write port.
// ----------------------------------------------------------------------------
module rwre_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  output rwre_pkg::cfg_t cfg
);
  import rwre_pkg::*;

  // Load reset values, then take writes by index
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeouts_before_reset <= TIMEOUTS_RST;
      cfg.min_rate_ms           <= MIN_RATE_RST;
      cfg.default_wait_ms       <= DEF_WAIT_RST;
      cfg.slack_ms              <= SLACK_RST;
      cfg.age_limit_ms          <= AGE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIMEOUTS: cfg.timeouts_before_reset <= cfg_data[7:0];
        REG_MIN_RATE: cfg.min_rate_ms           <= cfg_data[15:0];
        REG_DEF_WAIT: cfg.default_wait_ms       <= cfg_data[15:0];
        REG_SLACK:    cfg.slack_ms              <= cfg_data[15:0];
        REG_AGE:      cfg.age_limit_ms          <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[hdl/rwre_core.sv]
// ----------------------------------------------------------------------------
// Receiver watchdog core
// Watchdog state and the single-pass update that yields one result per item.
// ----------------------------------------------------------------------------
`include "receiver_watchdog_reset_escalation_defines.svh"

module rwre_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  rwre_pkg::item_t   item,
  input  rwre_pkg::cfg_t    cfg,
  output rwre_pkg::result_t res
);
  import rwre_pkg::*;

  logic [16:0] elapsed_ms, elapsed_ms_next;
  logic [7:0]  timeout_count, timeout_count_next;
  logic [1:0]  reset_level, reset_level_next;
  logic        seen_first_fix, seen_first_fix_next;
  logic [2:0]  mode_now, mode_now_next;
  logic [15:0] rate_now, rate_now_next;
  logic [31:0] last_uptime, last_uptime_next;

  logic [16:0] elapsed_inc;
  logic [7:0]  count_inc;
  logic        window_end;
  logic        req_ok;

  // Work out next state and the result for the item at hand
  always_comb begin
    elapsed_ms_next     = elapsed_ms;
    timeout_count_next  = timeout_count;
    reset_level_next    = reset_level;
    seen_first_fix_next = seen_first_fix;
    mode_now_next       = mode_now;
    rate_now_next       = rate_now;
    last_uptime_next    = last_uptime;
    res                 = '0;
    window_end          = 1'b0;
    req_ok              = (item.requested_mode <= MODE_HIGHEST);
    elapsed_inc = (elapsed_ms < ELAPSED_MAX) ? elapsed_ms + 17'd1 : elapsed_ms;
    count_inc   = (timeout_count < COUNT_MAX) ? timeout_count + 8'd1 : timeout_count;

    case (item.action)
      ACT_TICK: begin
        elapsed_ms_next = elapsed_inc;
        if (elapsed_inc >= wait_limit(rate_now, cfg)) begin
          elapsed_ms_next = '0;
          window_end      = 1'b1;
          if (seen_first_fix && mode_now != MODE_INACTIVE) begin
            res.timeout_event  = 1'b1;
            timeout_count_next = count_inc;
            // Escalate hot, warm, cold once the tolerance is used up
            if (count_inc > cfg.timeouts_before_reset) begin
              timeout_count_next = '0;
              res.reset_kind     = reset_level + 2'd1;
              if (reset_level < LEVEL_MAX) begin
                reset_level_next = reset_level + 2'd1;
              end
            end
          end
        end
      end
      ACT_FIX: begin
        res.fix_published   = 1'b1;
        elapsed_ms_next     = '0;
        window_end          = 1'b1;
        timeout_count_next  = '0;
        reset_level_next    = '0;
        last_uptime_next    = item.uptime_ms;
        seen_first_fix_next = 1'b1;
      end
      ACT_REQUEST: begin
        res.forward_request = req_ok && (item.requested_mode != mode_now);
      end
      ACT_APPLIED: begin
        res.mode_report_valid = 1'b1;
        if (item.apply_ok && req_ok) begin
          mode_now_next = item.requested_mode;
          if (item.requested_mode == MODE_INACTIVE) begin
            rate_now_next = RATE_UNKNOWN;
          end else if (item.requested_mode >= MODE_SAVE) begin
            rate_now_next = item.reported_rate_ms;
          end
        end
      end
      default: ;
    endcase

    // Age check at the end of a window while no reset is pending
    if (window_end && res.reset_kind == RESET_NONE && reset_level_next == 2'd0 &&
        last_uptime_next >= cfg.age_limit_ms) begin
      res.reset_kind = RESET_COLD;
    end

    res.current_mode_out = mode_now_next;
    res.wait_limit_ms    = wait_limit(rate_now_next, cfg);
  end

  // Hold state; advance on each item transfer into the result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed_ms     <= '0;
      timeout_count  <= '0;
      reset_level    <= '0;
      seen_first_fix <= 1'b0;
      mode_now       <= MODE_NONE;
      rate_now       <= RATE_UNKNOWN;
      last_uptime    <= '0;
    end else if (step) begin
      elapsed_ms     <= elapsed_ms_next;
      timeout_count  <= timeout_count_next;
      reset_level    <= reset_level_next;
      seen_first_fix <= seen_first_fix_next;
      mode_now       <= mode_now_next;
      rate_now       <= rate_now_next;
      last_uptime    <= last_uptime_next;
    end
  end

  `RWRE_ASSERT_ALWAYS(a_level_range, clk, rst, reset_level <= LEVEL_MAX, "reset level beyond cold")
  `RWRE_ASSERT_NEXT(a_fix_clears, clk, rst, step && item.action == ACT_FIX, timeout_count == 8'd0 && reset_level == 2'd0 && seen_first_fix, "fix did not clear counters")
  `RWRE_ASSERT_NEXT(a_warm_level, clk, rst, step && res.reset_kind == RESET_WARM, reset_level == LEVEL_MAX, "warm reset did not raise level")

endmodule

[hdl/receiver_watchdog_reset_escalation.sv]
// ----------------------------------------------------------------------------
// Receiver watchdog with reset escalation: input register, then result register.
// One item per cycle unless stalled; the update is one pass, input to result reg.
// Synchronous reset clears state and settings to defaults; no clearing pass.
// ----------------------------------------------------------------------------
`include "receiver_watchdog_reset_escalation_defines.svh"

module receiver_watchdog_reset_escalation (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [31:0] uptime_ms,
  input  logic [2:0]  requested_mode,
  input  logic        apply_ok,
  input  logic [15:0] reported_rate_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        fix_published,
  output logic        timeout_event,
  output logic [1:0]  reset_kind,
  output logic        forward_request,
  output logic        mode_report_valid,
  output logic [2:0]  current_mode_out,
  output logic [16:0] wait_limit_ms
);
  import rwre_pkg::*;

  cfg_t    cfg;
  item_t   item;
  logic    item_valid;
  result_t res_comb;
  result_t res;
  logic    advance;
  logic    take;

  rwre_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rwre_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (item),
    .cfg  (cfg),
    .res  (res_comb)
  );

  // Move the held item on when the result register is free or draining
  assign advance  = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !advance;
  assign take     = in_valid && !in_stall;

  // Input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (take) begin
      item.action           <= action_t'(action);
      item.uptime_ms        <= uptime_ms;
      item.requested_mode   <= requested_mode;
      item.apply_ok         <= apply_ok;
      item.reported_rate_ms <= reported_rate_ms;
    end
  end

  // Result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= advance || (out_valid && out_stall);
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_comb;
    end
  end

  assign fix_published     = res.fix_published;
  assign timeout_event     = res.timeout_event;
  assign reset_kind        = res.reset_kind;
  assign forward_request   = res.forward_request;
  assign mode_report_valid = res.mode_report_valid;
  assign current_mode_out  = res.current_mode_out;
  assign wait_limit_ms     = res.wait_limit_ms;

  `RWRE_ASSERT_NEXT(a_advance_shows, clk, rst, advance, out_valid, "advanced item lost")
  `RWRE_ASSERT_NEXT(a_stall_keeps_item, clk, rst, in_stall, item_valid, "stalled item dropped")

endmodule

[test/receiver_watchdog_reset_escalation_check.sv]
// ----------------------------------------------------------------------------
// Receiver watchdog checker
// Watches the settings port and both channels of the receiver watchdog. Each
// input transfer is run through a cycle-free model of the watchdog, and the
// predicted status is queued; each output transfer is compared field by field
// with the oldest queued status. Failures are counted and handed to the top.
// ----------------------------------------------------------------------------
module receiver_watchdog_reset_escalation_check
  import rwre_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  action,
  input  logic [31:0] uptime_ms,
  input  logic [2:0]  requested_mode,
  input  logic        apply_ok,
  input  logic [15:0] reported_rate_ms,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        fix_published,
  input  logic        timeout_event,
  input  logic [1:0]  reset_kind,
  input  logic        forward_request,
  input  logic        mode_report_valid,
  input  logic [2:0]  current_mode_out,
  input  logic [16:0] wait_limit_ms,
  output int          pending,
  output int          failures
);

  // Shadow settings and watchdog state
  cfg_t        settings;
  logic [16:0] elapsed;
  logic [7:0]  timeouts_seen;
  logic [1:0]  level;
  logic        fix_seen;
  logic [2:0]  mode;
  logic [15:0] rate;
  logic [31:0] uptime_last;

  result_t predicted_status[$];
  item_t   taken;
  result_t want;

  // Wait limit for the rate now in force, never below one
  function automatic logic [16:0] limit_in_force();
    logic [16:0] w;
    if (rate == RATE_UNKNOWN || rate < settings.min_rate_ms) begin
      w = {1'b0, settings.default_wait_ms};
    end else begin
      w = {1'b0, rate} + {1'b0, settings.slack_ms};
    end
    if (w == '0) begin
      w = 17'd1;
    end
    return w;
  endfunction

  // Advance the watchdog by one item and return the status it reports
  function automatic result_t advance_watchdog(input item_t it);
    result_t r;
    logic    window_end;
    r = '0;
    window_end = 1'b0;
    case (it.action)
      ACT_TICK: begin
        if (elapsed < ELAPSED_MAX) begin
          elapsed = elapsed + 17'd1;
        end
        if (elapsed >= limit_in_force()) begin
          elapsed = '0;
          window_end = 1'b1;
          // Count the timeout and escalate once the tolerance is exceeded
          if (fix_seen && mode != MODE_INACTIVE) begin
            r.timeout_event = 1'b1;
            if (timeouts_seen < COUNT_MAX) begin
              timeouts_seen = timeouts_seen + 8'd1;
            end
            if (timeouts_seen > settings.timeouts_before_reset) begin
              timeouts_seen = '0;
              r.reset_kind = (level == LEVEL_MAX) ? RESET_COLD : level + 2'd1;
              if (level < LEVEL_MAX) begin
                level = level + 2'd1;
              end
            end
          end
        end
      end
      ACT_FIX: begin
        r.fix_published = 1'b1;
        elapsed = '0;
        window_end = 1'b1;
        timeouts_seen = '0;
        level = '0;
        uptime_last = it.uptime_ms;
        fix_seen = 1'b1;
      end
      ACT_REQUEST: begin
        if (it.requested_mode <= MODE_HIGHEST && it.requested_mode != mode) begin
          r.forward_request = 1'b1;
        end
      end
      ACT_APPLIED: begin
        r.mode_report_valid = 1'b1;
        if (it.apply_ok && it.requested_mode <= MODE_HIGHEST) begin
          mode = it.requested_mode;
          if (mode == MODE_INACTIVE) begin
            rate = RATE_UNKNOWN;
          end else if (mode >= MODE_SAVE) begin
            rate = it.reported_rate_ms;
          end
        end
      end
      default: ;
    endcase
    // Old receiver: request a cold reset at a window end with nothing pending
    if (window_end && r.reset_kind == RESET_NONE && level == '0 &&
        uptime_last >= settings.age_limit_ms) begin
      r.reset_kind = RESET_COLD;
    end
    r.current_mode_out = mode;
    r.wait_limit_ms = limit_in_force();
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [31:0] exp_val,
                               input logic [31:0] got_val);
    if (exp_val !== got_val) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_val, got_val);
      failures = failures + 1;
    end
  endtask

  initial begin
    pending = 0;
    failures = 0;
  end

  // Track settings, predict on input transfers, compare on output transfers
  always @(posedge clk) begin
    if (rst) begin
      settings.timeouts_before_reset = TIMEOUTS_RST;
      settings.min_rate_ms = MIN_RATE_RST;
      settings.default_wait_ms = DEF_WAIT_RST;
      settings.slack_ms = SLACK_RST;
      settings.age_limit_ms = AGE_RST;
      elapsed = '0;
      timeouts_seen = '0;
      level = '0;
      fix_seen = 1'b0;
      mode = MODE_NONE;
      rate = RATE_UNKNOWN;
      uptime_last = '0;
      predicted_status.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TIMEOUTS: settings.timeouts_before_reset = cfg_data[7:0];
          REG_MIN_RATE: settings.min_rate_ms = cfg_data[15:0];
          REG_DEF_WAIT: settings.default_wait_ms = cfg_data[15:0];
          REG_SLACK:    settings.slack_ms = cfg_data[15:0];
          REG_AGE:      settings.age_limit_ms = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (predicted_status.size() == 0) begin
          $display("%0t: status transfer with none expected, got wait limit %0d",
                   $time, wait_limit_ms);
          failures = failures + 1;
        end else begin
          want = predicted_status.pop_front();
          compare_field("fix_published", 32'(want.fix_published), 32'(fix_published));
          compare_field("timeout_event", 32'(want.timeout_event), 32'(timeout_event));
          compare_field("reset_kind", 32'(want.reset_kind), 32'(reset_kind));
          compare_field("forward_request", 32'(want.forward_request),
                        32'(forward_request));
          compare_field("mode_report_valid", 32'(want.mode_report_valid),
                        32'(mode_report_valid));
          compare_field("current_mode_out", 32'(want.current_mode_out),
                        32'(current_mode_out));
          compare_field("wait_limit_ms", 32'(want.wait_limit_ms), 32'(wait_limit_ms));
        end
      end
      if (in_valid && !in_stall) begin
        taken.action = action_t'(action);
        taken.uptime_ms = uptime_ms;
        taken.requested_mode = requested_mode;
        taken.apply_ok = apply_ok;
        taken.reported_rate_ms = reported_rate_ms;
        predicted_status.push_back(advance_watchdog(taken));
      end
    end
    pending = predicted_status.size();
  end

endmodule

[test/receiver_watchdog_reset_escalation_test.sv]
// ----------------------------------------------------------------------------
// Receiver watchdog regression
// Drives the receiver watchdog with directed passes over ticks, fixes, mode
// requests and mode outcomes, then phases of random sequences under several
// settings, the extremes among them. The sender works in bursts and the
// receiver stalls on its own pattern; the checker beside the block predicts
// and compares every status transfer.
// ----------------------------------------------------------------------------
module receiver_watchdog_reset_escalation_test;
  import rwre_pkg::*;

  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          PHASES = 10;
  localparam int          PHASE_ITEMS = 130;
  localparam logic [2:0]  MODE_CAUTION = 3'd3;
  localparam logic [2:0]  MODE_INVALID = 3'd7;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_BURST
  } stall_style_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_TIMEOUTS;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  action = ACT_TICK;
  logic [31:0] uptime_ms = '0;
  logic [2:0]  requested_mode = MODE_NONE;
  logic        apply_ok = 1'b0;
  logic [15:0] reported_rate_ms = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        fix_published;
  logic        timeout_event;
  logic [1:0]  reset_kind;
  logic        forward_request;
  logic        mode_report_valid;
  logic [2:0]  current_mode_out;
  logic [16:0] wait_limit_ms;

  int           pending;
  int           failures;
  logic         in_took = 1'b0;
  int           idle_cycles = 0;
  int           burst_left = 0;
  logic         gaps_on = 1'b1;
  logic [7:0]   stall_age = '0;
  stall_style_t stall_style = STALL_NONE;
  cfg_t         setting;

  receiver_watchdog_reset_escalation uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .uptime_ms(uptime_ms), .requested_mode(requested_mode),
    .apply_ok(apply_ok), .reported_rate_ms(reported_rate_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .fix_published(fix_published), .timeout_event(timeout_event),
    .reset_kind(reset_kind), .forward_request(forward_request),
    .mode_report_valid(mode_report_valid), .current_mode_out(current_mode_out),
    .wait_limit_ms(wait_limit_ms)
  );

  receiver_watchdog_reset_escalation_check checker_inst (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .uptime_ms(uptime_ms), .requested_mode(requested_mode),
    .apply_ok(apply_ok), .reported_rate_ms(reported_rate_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .fix_published(fix_published), .timeout_event(timeout_event),
    .reset_kind(reset_kind), .forward_request(forward_request),
    .mode_report_valid(mode_report_valid), .current_mode_out(current_mode_out),
    .wait_limit_ms(wait_limit_ms),
    .pending(pending), .failures(failures)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Note input transfers and end the run when nothing moves for too long
  always @(posedge clk) begin
    in_took <= in_valid && !in_stall;
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver stall pattern: pick a new style each time the 8-bit age counter wraps
  always @(negedge clk) begin
    stall_age <= stall_age + 8'd1;
    if (stall_age == '0) begin
      stall_style <= stall_style_t'($urandom_range(0, 3));
    end
    case (stall_style)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 1) == 1);
      STALL_BURST: out_stall <= (stall_age[3:0] < 4'd6);
      default:     out_stall <= 1'b0;
    endcase
  end

  function automatic item_t make_item(input action_t a, input logic [31:0] up,
                                      input logic [2:0] m, input logic ok,
                                      input logic [15:0] r);
    item_t it;
    it.action = a;
    it.uptime_ms = up;
    it.requested_mode = m;
    it.apply_ok = ok;
    it.reported_rate_ms = r;
    return it;
  endfunction

  // Uptimes cluster around the age limit and the ends of the range
  function automatic logic [31:0] pick_uptime();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return setting.age_limit_ms;
      3: return setting.age_limit_ms - 32'd1;
      default: return $urandom;
    endcase
  endfunction

  // Rates mostly small so that windows close often
  function automatic logic [15:0] pick_rate();
    case ($urandom_range(0, 9))
      7: return 16'($urandom_range(0, 65535));
      8: return RATE_UNKNOWN;
      9: return setting.min_rate_ms;
      default: return 16'($urandom_range(0, 12));
    endcase
  endfunction

  function automatic item_t random_item(input action_t a);
    return make_item(a, pick_uptime(), 3'($urandom_range(0, MODE_HIGHEST)),
                     $urandom_range(0, 7) != 0, pick_rate());
  endfunction

  function automatic item_t noise_item();
    return make_item(action_t'($urandom_range(0, 3)), $urandom, 3'($urandom_range(0, 7)),
                     1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
  endfunction

  // Settings per phase: one all-high, one all-low, one at defaults, the rest small or random
  function automatic cfg_t phase_settings(input int p);
    cfg_t c;
    case (p)
      1: begin
        c.timeouts_before_reset = 8'hFF;
        c.min_rate_ms = 16'hFFFF;
        c.default_wait_ms = 16'hFFFF;
        c.slack_ms = 16'hFFFF;
        c.age_limit_ms = '1;
      end
      4: begin
        c.timeouts_before_reset = '0;
        c.min_rate_ms = '0;
        c.default_wait_ms = 16'd1;
        c.slack_ms = '0;
        c.age_limit_ms = '0;
      end
      7: begin
        c.timeouts_before_reset = TIMEOUTS_RST;
        c.min_rate_ms = MIN_RATE_RST;
        c.default_wait_ms = DEF_WAIT_RST;
        c.slack_ms = SLACK_RST;
        c.age_limit_ms = AGE_RST;
      end
      9: begin
        c.timeouts_before_reset = 8'($urandom_range(0, 255));
        c.min_rate_ms = 16'($urandom_range(0, 65535));
        c.default_wait_ms = 16'($urandom_range(1, 65535));
        c.slack_ms = 16'($urandom_range(0, 65535));
        c.age_limit_ms = $urandom;
      end
      default: begin
        c.timeouts_before_reset = 8'($urandom_range(0, 4));
        c.min_rate_ms = 16'($urandom_range(0, 8));
        c.default_wait_ms = 16'($urandom_range(1, 10));
        c.slack_ms = 16'($urandom_range(0, 6));
        c.age_limit_ms = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 1000);
      end
    endcase
    return c;
  endfunction

  // Present one item and hold it until the transfer; bursts end in a gap when gaps_on
  task automatic send_item(input item_t it);
    if (burst_left == 0) begin
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left = burst_left - 1;
    action <= it.action;
    uptime_ms <= it.uptime_ms;
    requested_mode <= it.requested_mode;
    apply_ok <= it.apply_ok;
    reported_rate_ms <= it.reported_rate_ms;
    in_valid <= 1'b1;
    do @(negedge clk); while (!in_took);
  endtask

  // Drop valid and wait until every status has come back
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic program_settings(input cfg_t c);
    cfg_index <= REG_TIMEOUTS;
    cfg_data <= {24'd0, c.timeouts_before_reset};
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_index <= REG_MIN_RATE;
    cfg_data <= {16'd0, c.min_rate_ms};
    @(negedge clk);
    cfg_index <= REG_DEF_WAIT;
    cfg_data <= {16'd0, c.default_wait_ms};
    @(negedge clk);
    cfg_index <= REG_SLACK;
    cfg_data <= {16'd0, c.slack_ms};
    @(negedge clk);
    cfg_index <= REG_AGE;
    cfg_data <= c.age_limit_ms;
    @(negedge clk);
    cfg_we <= 1'b0;
    setting = c;
  endtask

  initial begin
    int    sent;
    int    pick;
    int    run;
    cfg_t  tight;
    setting = phase_settings(7);
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: defaults, mode handling, age check on a fix
    send_item(make_item(ACT_TICK, '0, MODE_NONE, 1'b0, '0));
    send_item(make_item(ACT_REQUEST, '0, MODE_NONE, 1'b0, '0));
    send_item(make_item(ACT_REQUEST, '0, MODE_INVALID, 1'b1, '1));
    send_item(make_item(ACT_REQUEST, '0, MODE_HIGHEST, 1'b0, '0));
    send_item(make_item(ACT_APPLIED, '0, 3'd5, 1'b1, 16'd50));
    send_item(make_item(ACT_APPLIED, '0, MODE_SAVE, 1'b0, 16'd300));
    send_item(make_item(ACT_APPLIED, '0, MODE_SAVE, 1'b1, 16'd0));
    send_item(make_item(ACT_APPLIED, '0, MODE_CAUTION, 1'b1, RATE_UNKNOWN));
    send_item(make_item(ACT_APPLIED, '0, MODE_HIGHEST, 1'b1, 16'd150));
    send_item(make_item(ACT_FIX, '0, MODE_NONE, 1'b0, '0));
    send_item(make_item(ACT_FIX, '1, MODE_NONE, 1'b0, '0));
    send_item(make_item(ACT_APPLIED, '0, MODE_INACTIVE, 1'b1, 16'd40));
    send_item(make_item(ACT_APPLIED, '0, MODE_NONE, 1'b1, 16'd40));
    drain();

    // Directed: zero limit, escalation to cold, limit change mid-window
    tight.timeouts_before_reset = '0;
    tight.min_rate_ms = '0;
    tight.default_wait_ms = 16'd1;
    tight.slack_ms = '0;
    tight.age_limit_ms = '1;
    program_settings(tight);
    send_item(make_item(ACT_APPLIED, '0, MODE_CAUTION, 1'b1, 16'd0));
    send_item(make_item(ACT_FIX, 32'd5, MODE_NONE, 1'b0, '0));
    repeat (5) send_item(make_item(ACT_TICK, '0, MODE_NONE, 1'b0, '0));
    send_item(make_item(ACT_APPLIED, '0, MODE_SAVE, 1'b1, 16'd2));
    send_item(make_item(ACT_TICK, '0, MODE_NONE, 1'b0, '0));
    send_item(make_item(ACT_APPLIED, '0, MODE_SAVE, 1'b1, 16'd0));
    send_item(make_item(ACT_TICK, '0, MODE_NONE, 1'b0, '0));
    send_item(make_item(ACT_APPLIED, '0, MODE_INACTIVE, 1'b1, '0));
    send_item(make_item(ACT_TICK, '0, MODE_NONE, 1'b0, '0));
    send_item(make_item(ACT_FIX, '1, MODE_NONE, 1'b0, '0));
    drain();

    // Random phases: mostly tick runs between fixes and mode changes
    for (int p = 0; p < PHASES; p++) begin
      program_settings(phase_settings(p));
      gaps_on = (p % 3 != 2);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          run = $urandom_range(1, 12);
          repeat (run) send_item(random_item(ACT_TICK));
          sent = sent + run;
        end else begin
          if (pick < 57) begin
            send_item(random_item(ACT_FIX));
          end else if (pick < 67) begin
            send_item(random_item(ACT_REQUEST));
          end else if (pick < 85) begin
            send_item(random_item(ACT_APPLIED));
          end else begin
            send_item(noise_item());
          end
          sent = sent + 1;
        end
      end
      drain();
    end

    repeat (4) @(negedge clk);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/rwre_pkg.sv
hdl/rwre_cfg.sv
hdl/rwre_core.sv
hdl/receiver_watchdog_reset_escalation.sv
test/receiver_watchdog_reset_escalation_check.sv
test/receiver_watchdog_reset_escalation_test.sv
